// File: sv/filtered_varbyte_feature_histogram_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the filtered varbyte feature histogram
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FILTERED_VARBYTE_FEATURE_HISTOGRAM_ASSERT_SVH
`define FILTERED_VARBYTE_FEATURE_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define FVH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FVH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fvh_pkg.sv
// ----------------------------------------------------------------------------
// fvh_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fvh_pkg;

  localparam int FEATURE_DEPTH = 262144;
  localparam int EXCLUDE_DEPTH = 4096;

  localparam int FEAT_AW = $clog2(FEATURE_DEPTH);
  localparam int EXCL_AW = (EXCLUDE_DEPTH > 1) ? $clog2(EXCLUDE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(EXCLUDE_DEPTH + 1);

  localparam int REQ_W      = 2;
  localparam int ID_W       = 32;
  localparam int DATE_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int QIDX_W     = 18;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 32;
  localparam int LIMIT_W    = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int FEAT_LIMIT_RST = 262144;

  localparam int IN_FIELDS_W  = ID_W + DATE_W + BYTE_W + QIDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CNT_W + CNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_CODE   = 2'd2,
    REQ_QUERY  = 2'd3
  } fvh_req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_SKIP = 2'd1,
    ST_DROP = 2'd2,
    ST_FULL = 2'd3
  } fvh_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DATE   = 2'd0,
    CFG_MAX_DATE   = 2'd1,
    CFG_FEAT_LIMIT = 2'd2
  } fvh_cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_HDR_END,
    S_CNT_RD,
    S_CNT_WR,
    S_Q_CAP,
    S_DONE
  } fvh_state_t;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic load_do;
    logic hdr_start;
    logic srch_cmp;
    logic hdr_finish;
    logic code_do;
    logic cnt_wr;
    logic q_rd;
    logic q_cap;
    logic out_load;
  } fvh_cmd_t;

  typedef struct packed {
    fvh_req_t kind;
    logic     srch_done;
    logic     srch_hit;
    logic     cnt_need;
    logic     clr_last;
    logic     out_full;
  } fvh_sts_t;

endpackage

// File: sv/fvh_ram.sv
// ----------------------------------------------------------------------------
// fvh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fvh_datapath.sv
// ----------------------------------------------------------------------------
// fvh_datapath
// Item registers, decoder, binary search, counter RAM, config and output stage.
// ----------------------------------------------------------------------------
`include "filtered_varbyte_feature_histogram_assert.svh"

module fvh_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fvh_pkg::fvh_cmd_t             cmd,
  output fvh_pkg::fvh_sts_t             sts,
  input  logic [fvh_pkg::REQ_W-1:0]     req_type,
  input  logic [fvh_pkg::ID_W-1:0]      record_id,
  input  logic [fvh_pkg::DATE_W-1:0]    record_date,
  input  logic [fvh_pkg::BYTE_W-1:0]    code_byte,
  input  logic [fvh_pkg::QIDX_W-1:0]    query_index,
  input  logic                          cfg_we,
  input  logic [fvh_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [fvh_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fvh_pkg::STATUS_W-1:0]  status,
  output logic [fvh_pkg::CNT_W-1:0]     count_value,
  output logic [fvh_pkg::CNT_W-1:0]     documents,
  output logic                          record_active
);

  // configuration
  logic [fvh_pkg::DATE_W-1:0]  min_date_r, max_date_r;
  logic [fvh_pkg::LIMIT_W-1:0] feat_limit_r;

  // latched item
  fvh_pkg::fvh_req_t           kind_r;
  logic [fvh_pkg::ID_W-1:0]    id_r;
  logic [fvh_pkg::DATE_W-1:0]  date_r;
  logic [fvh_pkg::BYTE_W-1:0]  byte_r;
  logic [fvh_pkg::QIDX_W-1:0]  qidx_r;

  // block state
  logic [fvh_pkg::FILL_W-1:0]  fill_r;
  logic [fvh_pkg::CNT_W-1:0]   documents_r;
  logic [31:0]                 gap_r;
  logic [31:0]                 rf_r;
  logic                        active_r;

  // search
  logic [fvh_pkg::FILL_W-1:0]  lo_r, hiex_r;
  logic                        hit_r;

  logic                        cnt_need_r;
  logic [fvh_pkg::FEAT_AW-1:0] clr_addr_r;

  fvh_pkg::fvh_status_t        res_status_r;
  logic [fvh_pkg::CNT_W-1:0]   res_count_r;

  logic                        out_valid_r;
  fvh_pkg::fvh_status_t        out_status_r;
  logic [fvh_pkg::CNT_W-1:0]   out_count_r, out_docs_r;
  logic                        out_act_r;

  // combinational
  logic                        date_ok;
  logic [fvh_pkg::FILL_W:0]    mid_sum;
  logic [fvh_pkg::FILL_W-1:0]  mid;
  logic [31:0]                 gap_new, rf_sum, limit_ext, lim;
  logic                        code_end, in_range;
  logic [fvh_pkg::ID_W-1:0]    excl_rdata;
  logic                        excl_we;
  logic [fvh_pkg::CNT_W-1:0]   cnt_rdata, cnt_wdata, cnt_inc;
  logic                        cnt_we;
  logic [fvh_pkg::FEAT_AW-1:0] cnt_waddr, cnt_raddr;
  logic [31:0]                 qidx_ext;
  logic                        q_in_range;

  assign date_ok = (date_r >= min_date_r) && (date_r <= max_date_r);

  // floor((lo + hi) / 2) with hi = hiex - 1
  assign mid_sum = {1'b0, lo_r} + {1'b0, hiex_r} - {{fvh_pkg::FILL_W{1'b0}}, 1'b1};
  assign mid     = mid_sum[fvh_pkg::FILL_W:1];

  assign gap_new   = {gap_r[24:0], byte_r[6:0]};
  assign code_end  = byte_r[7];
  assign rf_sum    = rf_r + gap_new;
  assign limit_ext = 32'(feat_limit_r);
  assign lim       = (limit_ext < 32'(fvh_pkg::FEATURE_DEPTH)) ?
                     limit_ext : 32'(fvh_pkg::FEATURE_DEPTH);
  assign in_range  = rf_sum < lim;

  assign qidx_ext   = 32'(qidx_r);
  assign q_in_range = qidx_ext < 32'(fvh_pkg::FEATURE_DEPTH);

  assign cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;

  assign excl_we   = cmd.load_do && (fill_r < fvh_pkg::FILL_W'(fvh_pkg::EXCLUDE_DEPTH));
  assign cnt_we    = cmd.clr_step || cmd.cnt_wr;
  assign cnt_waddr = cmd.clr_step ? clr_addr_r : rf_r[fvh_pkg::FEAT_AW-1:0];
  assign cnt_wdata = cmd.clr_step ? '0 : cnt_inc;
  assign cnt_raddr = cmd.q_rd ? qidx_ext[fvh_pkg::FEAT_AW-1:0] : rf_r[fvh_pkg::FEAT_AW-1:0];

  fvh_ram #(
    .WIDTH (fvh_pkg::ID_W),
    .DEPTH (fvh_pkg::EXCLUDE_DEPTH)
  ) u_excl_ram (
    .clk   (clk),
    .we    (excl_we),
    .waddr (fill_r[fvh_pkg::EXCL_AW-1:0]),
    .wdata (id_r),
    .raddr (mid[fvh_pkg::EXCL_AW-1:0]),
    .rdata (excl_rdata)
  );

  fvh_ram #(
    .WIDTH (fvh_pkg::CNT_W),
    .DEPTH (fvh_pkg::FEATURE_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // control-side state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_date_r   <= '0;
      max_date_r   <= '1;
      feat_limit_r <= fvh_pkg::LIMIT_W'(fvh_pkg::FEAT_LIMIT_RST);
      fill_r       <= '0;
      documents_r  <= '0;
      gap_r        <= '0;
      rf_r         <= '0;
      active_r     <= 1'b0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (fvh_pkg::fvh_cfg_idx_t'(cfg_addr))
          fvh_pkg::CFG_MIN_DATE:   min_date_r   <= cfg_data;
          fvh_pkg::CFG_MAX_DATE:   max_date_r   <= cfg_data;
          fvh_pkg::CFG_FEAT_LIMIT: feat_limit_r <= cfg_data[fvh_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (excl_we) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.hdr_start) begin
        gap_r <= '0;
        rf_r  <= '0;
      end
      if (cmd.hdr_finish) begin
        active_r <= date_ok && !hit_r;
        if (date_ok && !hit_r && (documents_r != '1)) begin
          documents_r <= documents_r + 1'b1;
        end
      end
      if (cmd.code_do) begin
        if (code_end) begin
          rf_r  <= rf_sum;
          gap_r <= '0;
        end else begin
          gap_r <= gap_new;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r       <= fvh_pkg::fvh_req_t'(req_type);
      id_r         <= record_id;
      date_r       <= record_date;
      byte_r       <= code_byte;
      qidx_r       <= query_index;
      res_status_r <= fvh_pkg::ST_OK;
      res_count_r  <= '0;
    end
    if (cmd.load_do && !excl_we) begin
      res_status_r <= fvh_pkg::ST_FULL;
    end
    if (cmd.hdr_start) begin
      lo_r   <= '0;
      hiex_r <= fill_r;
      hit_r  <= 1'b0;
    end
    if (cmd.srch_cmp) begin
      if (excl_rdata == id_r) begin
        hit_r <= 1'b1;
      end else if (excl_rdata > id_r) begin
        hiex_r <= mid;
      end else begin
        lo_r <= mid + 1'b1;
      end
    end
    if (cmd.hdr_finish && !(date_ok && !hit_r)) begin
      res_status_r <= fvh_pkg::ST_SKIP;
    end
    if (cmd.code_do) begin
      cnt_need_r <= code_end && active_r && in_range;
      if (!active_r) begin
        res_status_r <= fvh_pkg::ST_SKIP;
      end else if (code_end && !in_range) begin
        res_status_r <= fvh_pkg::ST_DROP;
      end
    end
    if (cmd.q_cap) begin
      res_count_r <= q_in_range ? cnt_rdata : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_count_r  <= res_count_r;
      out_docs_r   <= documents_r;
      out_act_r    <= active_r;
    end
  end

  always_comb begin
    sts           = '0;
    sts.kind      = kind_r;
    sts.srch_done = !(lo_r < hiex_r) || !date_ok;
    sts.srch_hit  = excl_rdata == id_r;
    sts.cnt_need  = cnt_need_r;
    sts.clr_last  = clr_addr_r == fvh_pkg::FEAT_AW'(fvh_pkg::FEATURE_DEPTH - 1);
    sts.out_full  = out_valid_r && !out_tready;
  end

  assign out_tvalid    = out_valid_r;
  assign status        = out_status_r;
  assign count_value   = out_count_r;
  assign documents     = out_docs_r;
  assign record_active = out_act_r;

  `FVH_ASSERT_IMPLIES(a_fill_bounded, 1'b1,
    fill_r <= fvh_pkg::FILL_W'(fvh_pkg::EXCLUDE_DEPTH), "exclusion fill beyond table depth")
  `FVH_ASSERT_IMPLIES(a_cnt_wr_in_range, cmd.cnt_wr, rf_r < lim,
    "counter write to a feature outside the limit")
  `FVH_ASSERT_NEXT(a_docs_monotonic, 1'b1, documents_r >= $past(documents_r),
    "document total went down")

endmodule

// File: sv/fvh_ctrl.sv
// ----------------------------------------------------------------------------
// fvh_ctrl
// Sequencer: clearing pass, item dispatch, search probes and counter updates.
// ----------------------------------------------------------------------------
`include "filtered_varbyte_feature_histogram_assert.svh"

module fvh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output fvh_pkg::fvh_cmd_t cmd,
  input  fvh_pkg::fvh_sts_t sts
);

  fvh_pkg::fvh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fvh_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      fvh_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = fvh_pkg::S_IDLE;
      end
      fvh_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = fvh_pkg::S_DISPATCH;
        end
      end
      fvh_pkg::S_DISPATCH: begin
        unique case (sts.kind)
          fvh_pkg::REQ_LOAD: begin
            cmd.load_do = 1'b1;
            state_nxt   = fvh_pkg::S_DONE;
          end
          fvh_pkg::REQ_HEADER: begin
            cmd.hdr_start = 1'b1;
            state_nxt     = fvh_pkg::S_SRCH_RD;
          end
          fvh_pkg::REQ_CODE: begin
            cmd.code_do = 1'b1;
            state_nxt   = fvh_pkg::S_CNT_RD;
          end
          fvh_pkg::REQ_QUERY: begin
            cmd.q_rd  = 1'b1;
            state_nxt = fvh_pkg::S_Q_CAP;
          end
        endcase
      end
      // table read of the midpoint is issued here
      fvh_pkg::S_SRCH_RD: begin
        state_nxt = sts.srch_done ? fvh_pkg::S_HDR_END : fvh_pkg::S_SRCH_CMP;
      end
      fvh_pkg::S_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = sts.srch_hit ? fvh_pkg::S_HDR_END : fvh_pkg::S_SRCH_RD;
      end
      fvh_pkg::S_HDR_END: begin
        cmd.hdr_finish = 1'b1;
        state_nxt      = fvh_pkg::S_DONE;
      end
      // counter read at the running feature is issued here
      fvh_pkg::S_CNT_RD: begin
        state_nxt = sts.cnt_need ? fvh_pkg::S_CNT_WR : fvh_pkg::S_DONE;
      end
      fvh_pkg::S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = fvh_pkg::S_DONE;
      end
      fvh_pkg::S_Q_CAP: begin
        cmd.q_cap = 1'b1;
        state_nxt = fvh_pkg::S_DONE;
      end
      fvh_pkg::S_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = fvh_pkg::S_IDLE;
        end
      end
      default: state_nxt = fvh_pkg::S_IDLE;
    endcase
  end

  `FVH_ASSERT_NEXT(a_clear_once, state_r != fvh_pkg::S_CLEAR, state_r != fvh_pkg::S_CLEAR,
    "clearing pass re-entered outside reset")
  `FVH_ASSERT_IMPLIES(a_cnt_wr_needed, state_r == fvh_pkg::S_CNT_WR,
    $past(state_r) == fvh_pkg::S_CNT_RD && $past(sts.cnt_need), "unrequested counter write")
  `FVH_ASSERT_IMPLIES(a_probe_valid, state_r == fvh_pkg::S_SRCH_CMP,
    $past(state_r) == fvh_pkg::S_SRCH_RD && !$past(sts.srch_done), "probe past search end")

endmodule

// File: sv/filtered_varbyte_feature_histogram.sv
// Items are latched and dispatched one at a time: a load writes the exclusion
// table, a code byte decodes and may read and bump a counter, a query reads a
// counter and a header runs search probes (midpoint read, compare), up to 13.
// The next transfer comes in the cycle after the result is loaded. Reset
// (rst_n low, synchronous) clears control state, then a clearing pass zeroes
// the counter RAM; no item is taken until it ends.
// ----------------------------------------------------------------------------
// filtered_varbyte_feature_histogram
// Date/exclusion filtered record stream, varbyte gap decoder and feature counts.
// ----------------------------------------------------------------------------
module filtered_varbyte_feature_histogram (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // record_id, record_date, code_byte, query_index, zero fill
  input  logic [fvh_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [fvh_pkg::REQ_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // count_value, documents, record_active, zero fill
  output logic [fvh_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [fvh_pkg::STATUS_W-1:0]    out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fvh_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [fvh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DATE_LO = fvh_pkg::ID_W;
  localparam int BYTE_LO = DATE_LO + fvh_pkg::DATE_W;
  localparam int QIDX_LO = BYTE_LO + fvh_pkg::BYTE_W;

  fvh_pkg::fvh_cmd_t cmd;
  fvh_pkg::fvh_sts_t sts;

  logic [fvh_pkg::CNT_W-1:0] count_value, documents;
  logic                      record_active;

  assign cfg_ready = 1'b1;

  fvh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fvh_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (in_tuser),
    .record_id     (in_tdata[fvh_pkg::ID_W-1:0]),
    .record_date   (in_tdata[BYTE_LO-1:DATE_LO]),
    .code_byte     (in_tdata[QIDX_LO-1:BYTE_LO]),
    .query_index   (in_tdata[QIDX_LO+fvh_pkg::QIDX_W-1:QIDX_LO]),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .status        (out_tuser),
    .count_value   (count_value),
    .documents     (documents),
    .record_active (record_active)
  );

  assign out_tdata = fvh_pkg::OUT_TDATA_W'({record_active, documents, count_value});

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: filtered varbyte feature histogram
// Drives loads, record headers, code bytes and queries through the stream
// ports, predicts every reply from a model of the filter, decoder and counts
// held in a small scoreboard, and checks replies field by field. Runs several
// date windows and feature limits, including inverted and extreme ones, and
// ends with a stretch of records and queries without idling.
// ----------------------------------------------------------------------------
module tb;
  import fvh_pkg::*;

  localparam longint RUN_LIMIT     = 3000000;
  localparam bit [7:0] END_OF_NUMBER = 8'h80;

  typedef struct packed {
    fvh_req_t    kind;
    logic [31:0] rec_id;
    logic [31:0] rec_date;
    logic [7:0]  code;
    logic [17:0] qidx;
  } histo_item_t;

  typedef struct packed {
    fvh_status_t status;
    logic [31:0] count;
    logic [31:0] docs;
    logic        active;
  } histo_reply_t;

  class histogram_board;
    bit [31:0]    min_date = 32'd0;
    bit [31:0]    max_date = 32'hFFFF_FFFF;
    bit [18:0]    feature_limit = FEAT_LIMIT_RST;
    bit [31:0]    excl_ids[EXCLUDE_DEPTH];
    int unsigned  excl_fill = 0;
    bit [31:0]    counts[bit [31:0]];
    bit [31:0]    doc_total = 32'd0;
    bit [31:0]    gap_acc = 32'd0;
    bit [31:0]    feature_pos = 32'd0;
    bit           active = 1'b0;
    histo_reply_t pending_replies[$];
    int           errors = 0;

    function void set_reg(fvh_cfg_idx_t idx, bit [31:0] val);
      case (idx)
        CFG_MIN_DATE:   min_date = val;
        CFG_MAX_DATE:   max_date = val;
        CFG_FEAT_LIMIT: feature_limit = val[18:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] read_count(bit [31:0] idx);
      return counts.exists(idx) ? counts[idx] : 32'd0;
    endfunction

    // same midpoints as the hardware search, sorted or not
    function bit is_excluded(bit [31:0] id);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = int'(excl_fill) - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (excl_ids[mid] > id) hi = mid - 1;
        else if (excl_ids[mid] < id) lo = mid + 1;
        else return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(histo_item_t it);
      histo_reply_t want;
      bit [31:0]    lim;
      want.status = ST_OK;
      want.count  = 32'd0;
      case (it.kind)
        REQ_LOAD: begin
          if (excl_fill < EXCLUDE_DEPTH) begin
            excl_ids[excl_fill] = it.rec_id;
            excl_fill++;
          end else begin
            want.status = ST_FULL;
          end
        end
        REQ_HEADER: begin
          gap_acc = 32'd0;
          feature_pos = 32'd0;
          if (it.rec_date >= min_date && it.rec_date <= max_date && !is_excluded(it.rec_id)) begin
            active = 1'b1;
            if (doc_total != 32'hFFFF_FFFF) doc_total++;
          end else begin
            active = 1'b0;
            want.status = ST_SKIP;
          end
        end
        REQ_CODE: begin
          gap_acc = {gap_acc[24:0], it.code[6:0]};
          if (it.code[7]) begin
            feature_pos = feature_pos + gap_acc;
            gap_acc = 32'd0;
            if (active) begin
              lim = (feature_limit < FEATURE_DEPTH) ? feature_limit : FEATURE_DEPTH;
              if (feature_pos < lim) begin
                if (read_count(feature_pos) != 32'hFFFF_FFFF)
                  counts[feature_pos] = read_count(feature_pos) + 1;
              end else begin
                want.status = ST_DROP;
              end
            end
          end
          if (!active) want.status = ST_SKIP;
        end
        default: begin
          if (it.qidx < FEATURE_DEPTH) want.count = read_count(it.qidx);
        end
      endcase
      want.docs   = doc_total;
      want.active = active;
      pending_replies.push_back(want);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_reply(histo_reply_t got);
      histo_reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with nothing expected, got %0h", $time, got);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      compare("status", want.status, got.status);
      compare("count_value", want.count, got.count);
      compare("documents", want.docs, got.docs);
      compare("record_active", want.active, got.active);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  histogram_board sb = new();
  bit             quiet = 1'b0;
  int             gap_odds = 0;
  int             stall_level = 0;
  int             items_sent = 0;
  bit [31:0]      next_excl = 32'd0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  filtered_varbyte_feature_histogram uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // transfer monitor: replies checked before the new item is noted
  always @(posedge clk) begin
    histo_item_t  it;
    histo_reply_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = fvh_status_t'(out_tuser);
        got.count  = out_tdata[31:0];
        got.docs   = out_tdata[63:32];
        got.active = out_tdata[64];
        sb.check_reply(got);
      end
      if (in_tvalid && in_tready) begin
        it.kind     = fvh_req_t'(in_tuser);
        it.rec_id   = in_tdata[31:0];
        it.rec_date = in_tdata[63:32];
        it.code     = in_tdata[71:64];
        it.qidx     = in_tdata[89:72];
        sb.note_item(it);
      end
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      if ($urandom_range(0, 19) == 0) stall_level = $urandom_range(0, 5);
      if (!quiet && $urandom_range(0, 9) < stall_level) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic push_item(histo_item_t it);
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {6'd0, it.qidx, it.code, it.rec_date, it.rec_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // unused fields carry random bits
  task automatic send(fvh_req_t kind, bit [31:0] a, bit [31:0] b = 32'd0);
    histo_item_t it;
    it.kind = kind;
    it.rec_id = $urandom;
    it.rec_date = $urandom;
    it.code = 8'($urandom);
    it.qidx = 18'($urandom);
    case (kind)
      REQ_LOAD:   it.rec_id = a;
      REQ_HEADER: begin
        it.rec_id = a;
        it.rec_date = b;
      end
      REQ_CODE:   it.code = a[7:0];
      default:    it.qidx = a[17:0];
    endcase
    push_item(it);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(fvh_cfg_idx_t idx, bit [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_regs(bit [31:0] lo, bit [31:0] hi, bit [18:0] lim);
    drain();
    put_reg(CFG_MIN_DATE, lo);
    put_reg(CFG_MAX_DATE, hi);
    put_reg(CFG_FEAT_LIMIT, {13'd0, lim});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [31:0] next_id();
    next_excl = next_excl + $urandom_range(1, 2000);
    return next_excl;
  endfunction

  function automatic bit [31:0] pick_id();
    if (sb.excl_fill != 0 && $urandom_range(0, 9) < 3)
      return sb.excl_ids[$urandom_range(0, sb.excl_fill - 1)];
    return $urandom;
  endfunction

  function automatic bit [31:0] pick_date();
    bit [63:0] span;
    int        roll;
    roll = $urandom_range(0, 9);
    if (sb.min_date > sb.max_date || roll >= 8) return $urandom;
    if (roll == 0) return sb.min_date;
    if (roll == 1) return sb.max_date;
    span = {32'd0, sb.max_date} - sb.min_date + 1;
    return 32'(sb.min_date + ({32'd0, $urandom} % span));
  endfunction

  task automatic send_record();
    int roll;
    send(REQ_HEADER, pick_id(), pick_date());
    repeat ($urandom_range(0, 10)) begin
      roll = $urandom_range(0, 19);
      if (roll < 15) begin
        send(REQ_CODE, END_OF_NUMBER | $urandom_range(0, 15));
      end else if (roll < 18) begin
        send(REQ_CODE, $urandom_range(0, 3));
        send(REQ_CODE, END_OF_NUMBER | $urandom_range(0, 127));
      end else begin
        repeat ($urandom_range(1, 4)) send(REQ_CODE, $urandom_range(0, 255));
      end
    end
  endtask

  task automatic run_phase(bit [31:0] lo, bit [31:0] hi, bit [18:0] lim, int n);
    int           start;
    int           roll;
    histo_item_t  junk;
    write_regs(lo, hi, lim);
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 14) == 0) gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        send_record();
      end else if (roll < 75) begin
        send(REQ_QUERY, ($urandom_range(0, 4) != 0) ? $urandom_range(0, 320) : $urandom);
      end else if (roll < 87) begin
        send(REQ_LOAD, ($urandom_range(0, 6) != 0) ? next_id() : $urandom);
      end else begin
        junk = 92'({$urandom, $urandom, $urandom});
        junk.kind = fvh_req_t'($urandom_range(0, 3));
        push_item(junk);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: window edges, unsorted table, multi-byte and wrapping gaps
    write_regs(32'd100, 32'd200, 19'd262144);
    send(REQ_QUERY, 32'd0);
    send(REQ_QUERY, 32'h3FFFF);
    send(REQ_LOAD, 32'd50);
    send(REQ_LOAD, 32'd10);
    send(REQ_LOAD, 32'hFFFF_FFFF);
    send(REQ_LOAD, 32'd0);
    send(REQ_HEADER, 32'd7, 32'd100);
    send(REQ_CODE, 8'h83);
    send(REQ_CODE, 8'h01);
    send(REQ_CODE, 8'h80);
    send(REQ_CODE, 8'hFF);
    send(REQ_CODE, 8'h10);
    send(REQ_CODE, 8'h00);
    send(REQ_CODE, 8'h80);
    repeat (5) send(REQ_CODE, 8'h7F);
    send(REQ_CODE, 8'hFF);
    send(REQ_QUERY, 32'd3);
    send(REQ_QUERY, 32'd131);
    send(REQ_HEADER, 32'd10, 32'd200);
    send(REQ_CODE, 8'h85);
    send(REQ_HEADER, 32'd5, 32'd99);
    send(REQ_HEADER, 32'd5, 32'd201);
    // zero is loaded but lies where the search never probes
    send(REQ_HEADER, 32'd0, 32'd150);
    send(REQ_CODE, 8'h82);
    send(REQ_HEADER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    next_excl = 32'd100;

    run_phase(32'd0, 32'hFFFF_FFFF, 19'd262144, 90);
    // same settings again: sender holds off until all replies are in
    run_phase(32'd0, 32'hFFFF_FFFF, 19'd262144, 100);
    run_phase(32'd1000, 32'd50000, 19'd64, 150);
    run_phase(32'd60000, 32'd1000, 19'd300, 80);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 19'd1, 80);
    run_phase(32'd0, 32'd0, 19'd0, 80);
    run_phase(32'd0, 32'h7FFF_FFFF, 19'h7FFFF, 140);

    // last part: no idling
    quiet = 1'b1;
    write_regs(32'd0, 32'hFFFF_FFFF, 19'd262144);
    repeat (20) begin
      send_record();
      send(REQ_QUERY, $urandom_range(0, 200));
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("[filtered_varbyte_feature_histogram] OK");
    end else begin
      $display("[filtered_varbyte_feature_histogram] ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT * 20);
    $display("[filtered_varbyte_feature_histogram] ERROR");
    $finish;
  end

endmodule
